/* src/line_fifo_with_overrun_mark_macros.svh */
// Assertion macros for the line FIFO.
`ifndef LINE_FIFO_WITH_OVERRUN_MARK_MACROS_SVH
`define LINE_FIFO_WITH_OVERRUN_MARK_MACROS_SVH
`ifndef SYNTH
`define LFOM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define LFOM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LFOM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LFOM_ASSERT(lbl, clk, rst, prop, msg)
`define LFOM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LFOM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* src/lfom_pkg.sv */
package lfom_pkg;

  localparam int RING_DEPTH = 8192;
  localparam int MAX_DRAIN  = 64;

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int DRN_W  = $clog2(MAX_DRAIN + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int FILL_W = 14;
  localparam int SINK_W = 7;

  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 24;

  localparam logic [7:0] NEWLINE_MARK = 8'h0A;
  localparam logic [7:0] RESERVE_RST  = 8'd30;

  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_DRAIN = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  localparam logic REG_ENABLE  = 1'b0;
  localparam logic REG_RESERVE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic store;
    logic store_mark;
    logic mode_set;
    logic mode_clr;
    logic flush;
    logic rd_first;
    logic rd_next;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic admit;
    logic line_mode;
    logic full;
    logic drain_none;
    logic remain_zero;
    logic out_free;
  } stat_t;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

/* src/lfom_ctrl.sv */
module lfom_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [1:0]       kind,
  input  logic             first_of_line,
  input  logic             stream_enable,
  input  lfom_pkg::stat_t  stat,
  output lfom_pkg::cmd_t   cmd
);

  lfom_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfom_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      lfom_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && stream_enable) begin
          unique case (kind)
            lfom_pkg::KIND_LINE: begin
              if (first_of_line) begin
                if (stat.admit) begin
                  cmd.mode_set = 1'b1;
                  cmd.store    = !stat.full;
                end else begin
                  cmd.mode_clr   = 1'b1;
                  cmd.store      = !stat.full;
                  cmd.store_mark = 1'b1;
                end
              end else begin
                cmd.store = stat.line_mode && !stat.full;
              end
            end
            lfom_pkg::KIND_DRAIN: begin
              if (!stat.drain_none) begin
                cmd.rd_first = 1'b1;
                state_next   = lfom_pkg::ST_DRAIN;
              end
            end
            lfom_pkg::KIND_FLUSH: begin
              cmd.flush = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      lfom_pkg::ST_DRAIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.remain_zero) begin
            state_next = lfom_pkg::ST_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = lfom_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/lfom_dpath.sv */
`include "line_fifo_with_overrun_mark_macros.svh"

module lfom_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  lfom_pkg::cmd_t                   cmd,
  output lfom_pkg::stat_t                  stat,
  input  logic [7:0]                       data_byte,
  input  logic [7:0]                       line_length,
  input  logic [lfom_pkg::SINK_W-1:0]      sink_space,
  input  logic [7:0]                       overrun_reserve,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lfom_pkg::M_TDATA_W-1:0]   m_tdata,  // out_byte[7:0], fill_level[21:8]
  output logic                             m_tlast
);

  logic [7:0]                    ring [lfom_pkg::RING_DEPTH];
  logic [lfom_pkg::ADDR_W-1:0]   rd_ptr;
  logic [lfom_pkg::ADDR_W-1:0]   wr_ptr;
  logic [lfom_pkg::CNT_W-1:0]    fill;
  logic [lfom_pkg::DRN_W-1:0]    remain;
  logic                          line_mode;
  logic [7:0]                    rd_data;
  logic [7:0]                    out_byte;
  logic [lfom_pkg::FILL_W-1:0]   fill_level;
  logic                          rd_en;

  logic [lfom_pkg::CNT_W-1:0]    free_bytes;
  logic [lfom_pkg::DRN_W-1:0]    sink_cap;
  logic [lfom_pkg::DRN_W-1:0]    drain_n;

  assign rd_en      = cmd.rd_first || cmd.rd_next;
  assign free_bytes = lfom_pkg::CNT_W'(lfom_pkg::RING_DEPTH) - fill;
  assign sink_cap   = (sink_space > lfom_pkg::SINK_W'(lfom_pkg::MAX_DRAIN)) ?
                      lfom_pkg::DRN_W'(lfom_pkg::MAX_DRAIN) :
                      lfom_pkg::DRN_W'(sink_space);
  assign drain_n    = (lfom_pkg::CNT_W'(sink_cap) > fill) ?
                      lfom_pkg::DRN_W'(fill) : sink_cap;

  always_comb begin
    stat.admit       = lfom_pkg::SUM_W'(free_bytes) >=
                       (lfom_pkg::SUM_W'(line_length) + lfom_pkg::SUM_W'(overrun_reserve));
    stat.line_mode   = line_mode;
    stat.full        = fill == lfom_pkg::CNT_W'(lfom_pkg::RING_DEPTH);
    stat.drain_none  = drain_n == '0;
    stat.remain_zero = remain == '0;
    stat.out_free    = !m_tvalid || m_tready;
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring[wr_ptr] <= cmd.store_mark ? lfom_pkg::NEWLINE_MARK : data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ring[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      fill      <= '0;
      line_mode <= 1'b0;
      remain    <= '0;
    end else begin
      if (cmd.mode_set) begin
        line_mode <= 1'b1;
      end else if (cmd.mode_clr) begin
        line_mode <= 1'b0;
      end
      if (cmd.store) begin
        wr_ptr <= lfom_pkg::ptr_inc(wr_ptr);
        fill   <= fill + lfom_pkg::CNT_W'(1);
      end else if (rd_en) begin
        rd_ptr <= lfom_pkg::ptr_inc(rd_ptr);
        fill   <= fill - lfom_pkg::CNT_W'(1);
      end else if (cmd.flush) begin
        rd_ptr <= wr_ptr;
        fill   <= '0;
      end
      if (cmd.rd_first) begin
        remain <= drain_n - lfom_pkg::DRN_W'(1);
      end else if (cmd.rd_next) begin
        remain <= remain - lfom_pkg::DRN_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte   <= rd_data;
      fill_level <= lfom_pkg::FILL_W'(fill);
      m_tlast    <= remain == '0;
    end
  end

  assign m_tdata = {(lfom_pkg::M_TDATA_W - lfom_pkg::FILL_W - 8)'(0), fill_level, out_byte};

  `LFOM_ASSERT(a_fill_bound, clk, rst, fill <= lfom_pkg::CNT_W'(lfom_pkg::RING_DEPTH), "fill count above ring depth")
  `LFOM_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.store, !stat.full, "store into a full ring")
  `LFOM_ASSERT_IMP(a_no_underrun, clk, rst, rd_en, fill != '0, "read from an empty ring")
  `LFOM_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, !m_tvalid || m_tready, "output beat overwritten")
  `LFOM_ASSERT_NEXT(a_load_valid, clk, rst, cmd.out_load, m_tvalid, "loaded beat not presented")

endmodule

/* src/line_fifo_with_overrun_mark.sv */
// Line and flush beats leave the controller in idle, so s_tready stays high.
// Drain of n bytes: the first byte passes the ring read register and then the output register,
// then one byte per cycle while m_tready is high; input is held off until the last byte is loaded.
// Throughput is set by the single read port of the ring memory and the one output register.
// Synchronous reset: pointers, fill count and line mode clear, stream disabled, reserve 30.
// Ring contents are not cleared; only written entries are ever read.
module line_fifo_with_overrun_mark (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lfom_pkg::S_TDATA_W-1:0]   s_tdata,  // data_byte[7:0], line_length[15:8], sink_space[22:16]
  input  logic [lfom_pkg::S_TUSER_W-1:0]   s_tuser,  // kind[1:0], first_of_line[2]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lfom_pkg::M_TDATA_W-1:0]   m_tdata,  // out_byte[7:0], fill_level[21:8]
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [7:0]                       cfg_data
);

  logic            stream_enable;
  logic [7:0]      overrun_reserve;
  lfom_pkg::cmd_t  cmd;
  lfom_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_enable   <= 1'b0;
      overrun_reserve <= lfom_pkg::RESERVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfom_pkg::REG_ENABLE:  stream_enable   <= cfg_data[0];
        lfom_pkg::REG_RESERVE: overrun_reserve <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lfom_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .kind          (s_tuser[1:0]),
    .first_of_line (s_tuser[2]),
    .stream_enable (stream_enable),
    .stat          (stat),
    .cmd           (cmd)
  );

  lfom_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .data_byte       (s_tdata[7:0]),
    .line_length     (s_tdata[15:8]),
    .sink_space      (s_tdata[22:16]),
    .overrun_reserve (overrun_reserve),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast)
  );

endmodule
